FILE: hw/rtl/nmea_chk_pkg.sv
// Package for the NMEA sentence checker: beat types, character codes,
// status codes and the hex digit decoder. No dependencies.
`timescale 1ns / 1ps

package nmea_chk_pkg;

  // Characters that steer framing
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChBang   = 8'h21;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;

  // Shortest sentence that is checked further
  localparam int unsigned MinLen = 4;

  // Field count saturation point and width
  localparam int unsigned FieldW    = 6;
  localparam int unsigned MaxFields = 63;

  // Default saturation point of the length counters
  localparam int unsigned MaxLengthDef = 255;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TOO_SHORT   = 3'd1,
    ST_BAD_START   = 3'd2,
    ST_STAR_MISPL  = 3'd3,
    ST_BAD_HEX     = 3'd4,
    ST_MISMATCH    = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [FieldW-1:0] field_count;
    logic [7:0]        computed_sum;
    logic [7:0]        received_sum;
  } out_beat_t;

  // Decode one ASCII hex digit: bit 4 flags a valid digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    case (c) inside
      [8'h30:8'h39]: r = {1'b1, c[3:0]};
      [8'h41:8'h46],
      [8'h61:8'h66]: r = {1'b1, c[3:0] + 4'd9};
      default:       r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/nmea_sentence_checker_top.sv
// NMEA 0183 sentence checksum checker, top level.
// Depends on nmea_chk_pkg for beat types, character codes and status codes.
`timescale 1ns / 1ps

// Feed one sentence byte per beat on the input channel and mark its last byte
// with final_byte. The block takes one byte every cycle while in_ready_o is
// high: each byte is registered, then the framing counters, running XOR and
// star tracking are updated in the next cycle, and a final byte writes its
// verdict into the output register, so a result passes through the input
// register and then the output register. Input ready drops only while a
// final byte sits in the input register and the output register still holds
// an untaken result. Trailing CR/LF bytes are ignored; CR/LF followed by more
// bytes count as content. After each final byte all tracking state returns to
// its reset value. MAX_LENGTH sets where the length counters saturate.

module nmea_sentence_checker_top #(
  parameter int unsigned MAX_LENGTH = nmea_chk_pkg::MaxLengthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  nmea_chk_pkg::in_beat_t  in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output nmea_chk_pkg::out_beat_t out_data_o
);

  localparam int unsigned LenW = $clog2(MAX_LENGTH + 1);
  localparam int unsigned FW   = nmea_chk_pkg::FieldW;
  localparam logic [LenW-1:0] LenMax = LenW'(MAX_LENGTH);
  localparam logic [LenW-1:0] LenMin = LenW'(nmea_chk_pkg::MinLen);
  localparam logic [FW-1:0]   FldMax = FW'(nmea_chk_pkg::MaxFields);

  // Input register
  logic                   s1_valid_q;
  nmea_chk_pkg::in_beat_t s1_q;
  logic                   s1_go;

  // Sentence tracking state
  logic [LenW-1:0] len_q, len_d;
  logic [7:0]      start_q, start_d;
  logic [7:0]      run_xor_q, run_xor_d;
  logic [7:0]      body_xor_q, body_xor_d;
  logic            star_q, star_d;
  logic [1:0]      after_q, after_d;
  logic [7:0]      hi_q, hi_d;
  logic [7:0]      lo_q, lo_d;
  logic [FW-1:0]   comma_q, comma_d;
  logic [FW-1:0]   body_comma_q, body_comma_d;
  logic [LenW-1:0] pend_cnt_q, pend_cnt_d;
  logic [7:0]      pend_xor_q, pend_xor_d;

  // Output register
  logic                    out_valid_q;
  nmea_chk_pkg::out_beat_t out_q, res;

  // Advance the input register unless a final byte meets a stalled result
  assign s1_go      = !s1_q.final_byte || !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_data_i;
    end
  end

  // Next tracking state: flush held CR/LF, then take the byte as content
  always_comb begin
    logic [7:0]      b;
    logic            is_eol;
    logic [LenW-1:0] n;
    logic [LenW:0]   len_sum;
    logic [1:0]      k3;
    logic [2:0]      a_sum;
    logic [LenW-1:0] f_len;

    b      = s1_q.data_byte;
    is_eol = (b == nmea_chk_pkg::ChCr) || (b == nmea_chk_pkg::ChLf);

    len_d        = len_q;
    start_d      = start_q;
    run_xor_d    = run_xor_q;
    body_xor_d   = body_xor_q;
    star_d       = star_q;
    after_d      = after_q;
    hi_d         = hi_q;
    lo_d         = lo_q;
    comma_d      = comma_q;
    body_comma_d = body_comma_q;
    pend_cnt_d   = pend_cnt_q;
    pend_xor_d   = pend_xor_q;
    n            = pend_cnt_q;
    len_sum      = '0;
    k3           = 2'd0;
    a_sum        = 3'd0;
    f_len        = len_q;

    if (is_eol) begin
      // Hold the line-end byte until something follows it
      if (pend_cnt_q < LenMax) pend_cnt_d = pend_cnt_q + LenW'(1);
      pend_xor_d = pend_xor_q ^ b;
    end else begin
      if (pend_cnt_q != '0) begin
        if (len_q == '0) begin
          start_d = nmea_chk_pkg::ChCr;
          f_len   = LenW'(1);
          n       = pend_cnt_q - LenW'(1);
        end
        run_xor_d = run_xor_q ^ pend_xor_q;
        if (star_q) begin
          // Held bytes land in the hex digit slots as CR
          k3 = (n >= LenW'(3)) ? 2'd3 : n[1:0];
          if (after_q == 2'd0 && k3 != 2'd0) hi_d = nmea_chk_pkg::ChCr;
          if ((after_q == 2'd0 && k3 >= 2'd2) || (after_q == 2'd1 && k3 != 2'd0)) begin
            lo_d = nmea_chk_pkg::ChCr;
          end
          a_sum   = {1'b0, after_q} + {1'b0, k3};
          after_d = (a_sum > 3'd3) ? 2'd3 : a_sum[1:0];
        end
        len_sum = {1'b0, f_len} + {1'b0, n};
        f_len   = (len_sum > {1'b0, LenMax}) ? LenMax : len_sum[LenW-1:0];
      end
      pend_cnt_d = '0;
      pend_xor_d = 8'h00;

      if (f_len == '0) begin
        start_d = b;
      end else begin
        if (b == nmea_chk_pkg::ChStar) begin
          body_xor_d   = run_xor_d;
          body_comma_d = comma_q;
          star_d       = 1'b1;
          after_d      = 2'd0;
        end else if (star_d) begin
          if (after_d == 2'd0) hi_d = b;
          else if (after_d == 2'd1) lo_d = b;
          if (after_d != 2'd3) after_d = after_d + 2'd1;
        end
        if (b == nmea_chk_pkg::ChComma && comma_q < FldMax) comma_d = comma_q + FW'(1);
        run_xor_d = run_xor_d ^ b;
      end
      len_d = (f_len < LenMax) ? f_len + LenW'(1) : LenMax;
    end
  end

  // Judge the sentence from its updated state
  always_comb begin
    logic [4:0]  hd;
    logic [4:0]  ld;
    logic [FW:0] fld;
    logic [7:0]  recv;

    hd   = nmea_chk_pkg::hex_digit(hi_d);
    ld   = nmea_chk_pkg::hex_digit(lo_d);
    fld  = {1'b0, body_comma_d} + {{FW{1'b0}}, 1'b1};
    recv = {hd[3:0], ld[3:0]};
    res  = '0;
    if (len_d < LenMin) begin
      res.status = nmea_chk_pkg::ST_TOO_SHORT;
    end else if (start_d != nmea_chk_pkg::ChDollar && start_d != nmea_chk_pkg::ChBang) begin
      res.status = nmea_chk_pkg::ST_BAD_START;
    end else if (!star_d || after_d != 2'd2) begin
      res.status = nmea_chk_pkg::ST_STAR_MISPL;
    end else begin
      res.field_count  = (fld > {1'b0, FldMax}) ? FldMax : fld[FW-1:0];
      res.computed_sum = body_xor_d;
      if (!hd[4] || !ld[4]) begin
        res.status = nmea_chk_pkg::ST_BAD_HEX;
      end else begin
        res.received_sum = recv;
        res.status = (recv == body_xor_d) ? nmea_chk_pkg::ST_OK : nmea_chk_pkg::ST_MISMATCH;
      end
    end
  end

  // Update tracking state; clear it after a final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q        <= '0;
      start_q      <= 8'h00;
      run_xor_q    <= 8'h00;
      body_xor_q   <= 8'h00;
      star_q       <= 1'b0;
      after_q      <= 2'd0;
      hi_q         <= 8'h00;
      lo_q         <= 8'h00;
      comma_q      <= '0;
      body_comma_q <= '0;
      pend_cnt_q   <= '0;
      pend_xor_q   <= 8'h00;
    end else if (s1_valid_q && s1_go) begin
      if (s1_q.final_byte) begin
        len_q        <= '0;
        start_q      <= 8'h00;
        run_xor_q    <= 8'h00;
        body_xor_q   <= 8'h00;
        star_q       <= 1'b0;
        after_q      <= 2'd0;
        hi_q         <= 8'h00;
        lo_q         <= 8'h00;
        comma_q      <= '0;
        body_comma_q <= '0;
        pend_cnt_q   <= '0;
        pend_xor_q   <= 8'h00;
      end else begin
        len_q        <= len_d;
        start_q      <= start_d;
        run_xor_q    <= run_xor_d;
        body_xor_q   <= body_xor_d;
        star_q       <= star_d;
        after_q      <= after_d;
        hi_q         <= hi_d;
        lo_q         <= lo_d;
        comma_q      <= comma_d;
        body_comma_q <= body_comma_d;
        pend_cnt_q   <= pend_cnt_d;
        pend_xor_q   <= pend_xor_d;
      end
    end
  end

  // Load the result register on a final byte, drop it when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_valid_q && s1_go && s1_q.final_byte) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_go && s1_q.final_byte) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A final beat leaves the tracking state cleared
  a_clear_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_go && s1_q.final_byte |=>
      len_q == '0 && pend_cnt_q == '0 && !star_q && comma_q == '0)
    else $error("tracking state not cleared after final byte");

  // Digit slots only fill once a star is seen
  a_after_needs_star: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !star_q |-> after_q == 2'd0)
    else $error("after-star count set without a star");

  // No content tracked before the start byte
  a_empty_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q == '0 |-> !star_q && comma_q == '0 && run_xor_q == 8'h00)
    else $error("content state set with zero length");

  // Framing errors report zero fields
  a_framing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status == nmea_chk_pkg::ST_TOO_SHORT ||
                    out_q.status == nmea_chk_pkg::ST_BAD_START ||
                    out_q.status == nmea_chk_pkg::ST_STAR_MISPL) |->
      out_q.field_count == '0 && out_q.computed_sum == 8'h00 &&
      out_q.received_sum == 8'h00)
    else $error("framing error with nonzero result fields");

endmodule

FILE: test/tb.sv
// Self-checking bench for nmea_sentence_checker_top: directed and random sentences.
// Depends on nmea_chk_pkg for beat types, character codes and status codes.
`timescale 1ns / 1ps

module tb;
  import nmea_chk_pkg::*;

  localparam int unsigned LenCap      = 255;
  localparam int unsigned BytesWanted = 1850;
  localparam int unsigned CycleLimit  = 400000;

  // Tracks sentence framing and XOR, and queues the verdict due at each final byte
  class verdict_board;
    out_beat_t   verdicts_due[$];
    int          n_fail;
    int unsigned len_cnt;
    int unsigned eol_cnt;
    int unsigned after_cnt;
    int unsigned comma_cnt;
    int unsigned body_comma;
    logic [7:0]  start_ch;
    logic [7:0]  run_xor;
    logic [7:0]  body_xor;
    logic [7:0]  hex_hi;
    logic [7:0]  hex_lo;
    logic [7:0]  eol_xor;
    bit          star_seen;

    function new();
      n_fail = 0;
      clear();
    endfunction

    function void clear();
      len_cnt    = 0;
      eol_cnt    = 0;
      after_cnt  = 0;
      comma_cnt  = 0;
      body_comma = 0;
      start_ch   = '0;
      run_xor    = '0;
      body_xor   = '0;
      hex_hi     = '0;
      hex_lo     = '0;
      eol_xor    = '0;
      star_seen  = 1'b0;
    endfunction

    function int hex_val(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      return -1;
    endfunction

    function void grow(int unsigned n);
      len_cnt += n;
      if (len_cnt > LenCap) len_cnt = LenCap;
    endfunction

    // Store a byte in the hex digit slots after the star
    function void fill_slot(logic [7:0] c);
      if (after_cnt == 0) hex_hi = c;
      else if (after_cnt == 1) hex_lo = c;
      if (after_cnt < 3) after_cnt++;
    endfunction

    // Turn held CR/LF bytes into content once a later byte shows up
    function void release_eol();
      int unsigned n;
      n = eol_cnt;
      if (n == 0) return;
      if (len_cnt == 0) begin
        start_ch = ChCr;
        grow(1);
        n--;
      end
      run_xor ^= eol_xor;
      if (star_seen) begin
        for (int unsigned k = 0; k < n && k < 3; k++) fill_slot(ChCr);
      end
      grow(n);
      eol_cnt = 0;
      eol_xor = '0;
    endfunction

    function void absorb(logic [7:0] b);
      if (len_cnt == 0) begin
        start_ch = b;
      end else begin
        if (b == ChStar) begin
          body_xor   = run_xor;
          body_comma = comma_cnt;
          star_seen  = 1'b1;
          after_cnt  = 0;
        end else if (star_seen) begin
          fill_slot(b);
        end
        if (b == ChComma && comma_cnt < MaxFields) comma_cnt++;
        run_xor ^= b;
      end
      grow(1);
    endfunction

    // Note one accepted input beat
    function void note_byte(in_beat_t beat);
      out_beat_t   v;
      int          hi;
      int          lo;
      int unsigned fc;
      if (beat.data_byte == ChCr || beat.data_byte == ChLf) begin
        if (eol_cnt < LenCap) eol_cnt++;
        eol_xor ^= beat.data_byte;
      end else begin
        release_eol();
        absorb(beat.data_byte);
      end
      if (!beat.final_byte) return;
      v = '0;
      if (len_cnt < MinLen) begin
        v.status = ST_TOO_SHORT;
      end else if (start_ch != ChDollar && start_ch != ChBang) begin
        v.status = ST_BAD_START;
      end else if (!star_seen || after_cnt != 2) begin
        v.status = ST_STAR_MISPL;
      end else begin
        fc = body_comma + 1;
        if (fc > MaxFields) fc = MaxFields;
        v.field_count  = fc[FieldW-1:0];
        v.computed_sum = body_xor;
        hi = hex_val(hex_hi);
        lo = hex_val(hex_lo);
        if (hi < 0 || lo < 0) begin
          v.status = ST_BAD_HEX;
        end else begin
          v.received_sum = {hi[3:0], lo[3:0]};
          v.status = (v.received_sum == body_xor) ? ST_OK : ST_MISMATCH;
        end
      end
      verdicts_due.push_back(v);
      clear();
    endfunction

    // Compare one accepted result beat with the oldest verdict due
    function void check_verdict(out_beat_t got);
      out_beat_t exp;
      if (verdicts_due.size() == 0) begin
        $error("result beat with no verdict due: %h", got);
        n_fail++;
        return;
      end
      exp = verdicts_due.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        n_fail++;
      end
      if (got.field_count !== exp.field_count) begin
        $error("field_count: expected %0d, got %0d", exp.field_count, got.field_count);
        n_fail++;
      end
      if (got.computed_sum !== exp.computed_sum) begin
        $error("computed_sum: expected %h, got %h", exp.computed_sum, got.computed_sum);
        n_fail++;
      end
      if (got.received_sum !== exp.received_sum) begin
        $error("received_sum: expected %h, got %h", exp.received_sum, got.received_sum);
        n_fail++;
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_beat_t out_data_o;

  verdict_board board = new();
  logic [7:0]   line_q[$];
  int unsigned  bytes_sent;
  int unsigned  cycles;
  int unsigned  stall_left;
  bit           gaps_on;
  bit           stall_on;

  nmea_sentence_checker_top #(
    .MAX_LENGTH(LenCap)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Take result beats and stall the output side in random bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) board.check_verdict(out_data_o);
      if (stall_left > 0) begin
        stall_left  <= stall_left - 1;
        out_ready_i <= (stall_left == 1);
      end else if (stall_on && $urandom_range(0, 9) == 0) begin
        stall_left  <= $urandom_range(1, 10);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("nmea_sentence_checker_top test failed");
      $finish;
    end
  end

  function void put_str(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function logic [7:0] hex_char(logic [3:0] n, bit lower);
    if (n < 10) return 8'h30 + n;
    return 8'((lower ? 8'h61 : 8'h41) + n - 10);
  endfunction

  function void put_hex(logic [7:0] v, bit lower);
    line_q.push_back(hex_char(v[7:4], lower));
    line_q.push_back(hex_char(v[3:0], lower));
  endfunction

  // Close the body with a star and its checksum, optionally corrupted
  function void put_star_sum(logic [7:0] corrupt, bit lower);
    logic [7:0] sum;
    sum = '0;
    for (int i = 1; i < line_q.size(); i++) sum ^= line_q[i];
    line_q.push_back(ChStar);
    put_hex(sum ^ corrupt, lower);
  endfunction

  function void put_eol(int unsigned n);
    for (int unsigned i = 0; i < n; i++) line_q.push_back($urandom_range(0, 1) ? ChCr : ChLf);
  endfunction

  // Printable body character without a star, commas favored
  function logic [7:0] body_char();
    logic [7:0] c;
    if ($urandom_range(0, 4) == 0) return ChComma;
    c = 8'($urandom_range(32, 126));
    return (c == ChStar) ? ChComma : c;
  endfunction

  function void put_body(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 30) == 0) line_q.push_back($urandom_range(0, 1) ? ChCr : ChLf);
      else line_q.push_back(body_char());
    end
  endfunction

  // Offer one beat, with an optional idle burst ahead of it
  task send_byte(input logic [7:0] b, input logic fin);
    in_beat_t beat;
    beat.data_byte  = b;
    beat.final_byte = fin;
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_byte(beat);
  endtask

  task ship_line();
    for (int i = 0; i < line_q.size(); i++) send_byte(line_q[i], i == line_q.size() - 1);
    bytes_sent += line_q.size();
    line_q.delete();
  endtask

  // Hold off input until every due verdict is out
  task drain();
    in_valid_i <= 1'b0;
    while (board.verdicts_due.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned pick;
    int unsigned n;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    stall_left  = 0;
    cycles      = 0;
    bytes_sent  = 0;
    gaps_on     = 1'b1;
    stall_on    = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sentences: good ones, each status, held CR/LF cases, saturation
    put_str("$GPGGA,123,,4.5"); put_star_sum(8'h00, 1'b0); put_eol(2); ship_line();
    put_str("!AIVDM,1,1,,B"); put_star_sum(8'h00, 1'b1); ship_line();
    put_str("$GPRMC,A,B"); put_star_sum(8'h01, 1'b0); line_q.push_back(ChCr); ship_line();
    put_str("$AB*G1"); ship_line();
    put_str("$AB*1g"); ship_line();
    put_str("#AB"); put_star_sum(8'h00, 1'b0); ship_line();
    put_str("$*"); ship_line();
    put_str("$"); ship_line();
    line_q.push_back(ChCr); ship_line();
    put_str("$GPTXT,hello"); ship_line();
    put_str("$AB*4"); ship_line();
    put_str("$AB*411"); ship_line();
    put_str("$A"); line_q.push_back(ChCr); put_str("B"); put_star_sum(8'h00, 1'b0); ship_line();
    line_q.push_back(ChLf); put_str("$AB"); put_star_sum(8'h00, 1'b0); ship_line();
    put_str("$AB*"); line_q.push_back(ChLf); put_str("5"); ship_line();
    put_str("$AB*"); line_q.push_back(ChCr); line_q.push_back(ChLf); put_str("Z"); ship_line();
    put_str("$A*B,C"); put_star_sum(8'h00, 1'b0); ship_line();
    line_q.push_back(ChDollar);
    for (int i = 0; i < 70; i++) line_q.push_back(ChComma);
    put_star_sum(8'h00, 1'b0); put_eol(1); ship_line();
    line_q.push_back(ChBang);
    for (int i = 0; i < 300; i++) line_q.push_back(body_char());
    put_star_sum(8'h00, 1'b0); ship_line();
    line_q.push_back(ChDollar);
    line_q.push_back(8'h00); line_q.push_back(8'hFF);
    line_q.push_back(8'h7F); line_q.push_back(8'h80);
    put_star_sum(8'h00, 1'b1); ship_line();
    put_str("$FF*ff"); ship_line();
    drain();

    // Random sentences: mostly well framed, some broken, some noise
    while (bytes_sent < BytesWanted) begin
      if (bytes_sent + 300 > BytesWanted) begin
        gaps_on  = 1'b0;
        stall_on = 1'b0;
      end else begin
        gaps_on  = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 90) begin
        line_q.push_back($urandom_range(0, 1) ? ChDollar : ChBang);
        n = ($urandom_range(0, 79) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 20);
        put_body(n);
      end
      if (pick < 72) begin
        put_star_sum(($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : 8'h00,
                     1'($urandom_range(0, 1)));
        put_eol($urandom_range(0, 3));
      end else if (pick < 90) begin
        // Break the framing in one of several ways
        case ($urandom_range(0, 5))
          0: begin
            line_q[0] = 8'($urandom_range(0, 255));
            put_star_sum(8'h00, 1'b0);
          end
          1: begin
            put_star_sum(8'h00, 1'b0);
            void'(line_q.pop_back());
          end
          2: begin
            put_star_sum(8'h00, 1'b1);
            line_q.push_back(body_char());
          end
          3: begin
            put_star_sum(8'h00, 1'b0);
            line_q[line_q.size() - $urandom_range(1, 2)] = 8'($urandom_range(0, 255));
          end
          4: ;
          default: begin
            line_q.push_back(ChStar);
            put_eol($urandom_range(1, 3));
            line_q.push_back(hex_char(4'($urandom_range(0, 15)), 1'b0));
          end
        endcase
        put_eol($urandom_range(0, 2));
      end else begin
        n = $urandom_range(1, 12);
        for (int unsigned i = 0; i < n; i++) line_q.push_back(8'($urandom_range(0, 255)));
      end
      ship_line();
      if (pick == 50) drain();
    end

    // Let the last results out, then report
    drain();
    repeat (20) @(posedge clk_i);
    if (board.n_fail == 0 && board.verdicts_due.size() == 0) begin
      $display("nmea_sentence_checker_top test passed");
    end else begin
      $display("nmea_sentence_checker_top test failed");
    end
    $finish;
  end

endmodule
